// File: design/gfd_pkg.sv
// ----------------------------------------------------------------------------
// GPS frame decoder package
// Shared types, constants and character helpers for the position frame decoder.
// ----------------------------------------------------------------------------
package gfd_pkg;

    localparam int FRAME_LEN     = 13;
    localparam int SEXTET_COUNT  = FRAME_LEN - 2;
    localparam int FIELD_BITS    = 6 * SEXTET_COUNT;
    localparam int POS_W         = 4;

    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0] HEADER_RESET = 8'h24;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_HEADER   = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       frame_start;
    } char_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  lat_deg;
        logic [7:0]  lat_min;
        logic [15:0] lat_dmin;
        logic        lat_north;
        logic [7:0]  lon_deg;
        logic [7:0]  lon_min;
        logic [15:0] lon_dmin;
        logic        lon_east;
    } fix_t;

    // One beat handed from the input register to the frame logic
    typedef struct packed {
        logic  step;
        char_t item;
    } gfd_step_t;

    typedef struct packed {
        logic last;
        fix_t fix;
    } gfd_rsp_t;

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [5:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                v = 6'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A)
                v = 6'(c - 8'h61 + 8'd26);
            else if (c >= 8'h30 && c <= 8'h39)
                v = 6'(c - 8'h30 + 8'd52);
            else if (c == CHAR_AMP)
                v = 6'd62;
            else
                v = 6'd63;
            return v;
        end
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v <= 6'd25)
                c = 8'h41 + {2'b00, v};
            else if (v <= 6'd51)
                c = 8'h61 + {2'b00, v} - 8'd26;
            else if (v <= 6'd61)
                c = 8'h30 + {2'b00, v} - 8'd52;
            else if (v == 6'd62)
                c = CHAR_AMP;
            else
                c = CHAR_SLASH;
            return c;
        end
    endfunction

    // Odd bits weigh 2, even bits weigh 3; max total is 20
    function automatic logic [4:0] char_weight(input logic [7:0] c);
        logic [4:0] w;
        begin
            w = 5'd0;
            for (int i = 0; i < 4; i++) begin
                w = w + {3'b000, c[2*i+1], 1'b0} + (c[2*i] ? 5'd3 : 5'd0);
            end
            return w;
        end
    endfunction

endpackage

// File: design/gfd_frame.sv
// ----------------------------------------------------------------------------
// GPS frame decoder: frame tracking
// Holds frame position, checksum and decoded sextets; builds the result.
// ----------------------------------------------------------------------------
module gfd_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        header_char,
    input  gfd_pkg::gfd_step_t req,
    output gfd_pkg::gfd_rsp_t  rsp
);
    import gfd_pkg::*;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [5:0]            sum_reg, sum_next;
    logic                  stopped_reg, stopped_next;
    logic                  hdr_good_reg, hdr_good_next;
    logic [FIELD_BITS-1:0] sextet_reg, sextet_next;

    logic [7:0] c;
    logic [5:0] add_sum;
    logic       in_frame;
    logic       frame_last;
    fix_t       fix_comb;

    assign c        = req.item.ch;
    assign in_frame = (pos_reg != POS_IDLE) && (pos_reg <= POS_LAST);
    assign add_sum  = sum_reg + {1'b0, char_weight(c)};

    assign frame_last = !req.item.frame_start && (pos_reg == POS_LAST);
    assign rsp        = {frame_last, fix_comb};

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        stopped_next  = stopped_reg;
        hdr_good_next = hdr_good_reg;
        sextet_next   = sextet_reg;
        if (req.step) begin
            if (req.item.frame_start) begin
                hdr_good_next = (c == header_char);
                stopped_next  = (c == CHAR_NUL);
                sum_next      = (c == CHAR_NUL) ? 6'd0 : {1'b0, char_weight(c)};
                pos_next      = POS_W'(1);
            end else if (!in_frame || frame_last) begin
                pos_next = POS_IDLE;
            end else begin
                sextet_next = {sextet_reg[FIELD_BITS-7:0], digit_value(c)};
                if (!stopped_reg) begin
                    if (c == CHAR_NUL)
                        stopped_next = 1'b1;
                    else
                        sum_next = add_sum;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        fix_comb = '0;
        if (!hdr_good_reg) begin
            fix_comb.status = STATUS_HEADER;
        end else if (digit_char(sum_reg) != c) begin
            fix_comb.status = STATUS_CHECKSUM;
        end else begin
            fix_comb.status    = STATUS_GOOD;
            fix_comb.lat_deg   = sextet_reg[65:58];
            fix_comb.lat_min   = sextet_reg[57:50];
            fix_comb.lat_dmin  = sextet_reg[49:34];
            fix_comb.lon_deg   = sextet_reg[33:26];
            fix_comb.lon_min   = sextet_reg[25:18];
            fix_comb.lon_dmin  = sextet_reg[17:2];
            fix_comb.lat_north = sextet_reg[1];
            fix_comb.lon_east  = sextet_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= POS_IDLE;
            sum_reg      <= 6'd0;
            stopped_reg  <= 1'b0;
            hdr_good_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            stopped_reg  <= stopped_next;
            hdr_good_reg <= hdr_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sextet_reg <= sextet_next;
    end

endmodule

// File: design/gps_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// GPS frame decoder top level
// Character stream in, one decoded position fix out per 13-character frame.
// ----------------------------------------------------------------------------
// Takes one character beat per clock. A character lands in an input register,
// is decoded and folded into the frame state when it leaves that register,
// and the checksum character of a frame produces one fix beat in the output
// register on that same edge, so the last character passes the input register
// and the output register before fix_valid rises. Throughput is one character
// per cycle; the input stalls only while a fix waits in a stalled output
// register and the held character would produce another fix.
// header_char may be written at any time the decoder is idle; cfg_ready is
// always high.
module gps_frame_decoder_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           char_valid,
    output logic           char_stall,
    input  gfd_pkg::char_t char_data,
    output logic           fix_valid,
    input  logic           fix_stall,
    output gfd_pkg::fix_t  fix_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);
    import gfd_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    char_t     s1_data_reg;
    logic      out_valid_reg, out_valid_next;
    fix_t      out_data_reg;
    logic [7:0] header_reg;

    gfd_step_t req;
    gfd_rsp_t  rsp;
    logic      out_free;
    logic      s1_advance;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !fix_stall;
    assign s1_advance = s1_valid_reg && (!rsp.last || out_free);
    assign char_stall = s1_valid_reg && !s1_advance;

    assign req = {s1_advance, s1_data_reg};

    gfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_char (header_reg),
        .req         (req),
        .rsp         (rsp)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!char_stall)
            s1_valid_next = char_valid;
        out_valid_next = out_valid_reg;
        if (s1_advance && rsp.last)
            out_valid_next = 1'b1;
        else if (!fix_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RESET;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                header_reg <= cfg_data;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            s1_data_reg <= char_data;
        if (s1_advance && rsp.last)
            out_data_reg <= rsp.fix;
    end

    assign fix_valid = out_valid_reg;
    assign fix_data  = out_data_reg;

endmodule

// File: design/gfd_checker.sv
// ----------------------------------------------------------------------------
// GPS frame decoder port checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gfd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           char_valid,
    input logic           char_stall,
    input logic           fix_valid,
    input logic           fix_stall,
    input gfd_pkg::fix_t  fix_data
);
    import gfd_pkg::*;

    // Hold a stalled fix beat
    a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix_stall |=> fix_valid && $stable(fix_data))
        else $error("fix beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid |-> (fix_data.status == STATUS_GOOD ||
                       fix_data.status == STATUS_HEADER ||
                       fix_data.status == STATUS_CHECKSUM))
        else $error("fix status out of range");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fix_valid && fix_data.status != STATUS_GOOD |->
            fix_data.lat_deg == 8'd0 && fix_data.lat_min == 8'd0 &&
            fix_data.lat_dmin == 16'd0 && !fix_data.lat_north &&
            fix_data.lon_deg == 8'd0 && fix_data.lon_min == 8'd0 &&
            fix_data.lon_dmin == 16'd0 && !fix_data.lon_east)
        else $error("failed fix carries nonzero fields");

    // A fresh fix must come from an accepted character that has passed the input register
    a_fix_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fix_valid) |-> $past(char_valid && !char_stall, 2))
        else $error("fix appeared without a preceding character");

endmodule

bind gps_frame_decoder_top gfd_checker u_gfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .fix_valid  (fix_valid),
    .fix_stall  (fix_stall),
    .fix_data   (fix_data)
);
